// ===== rtl/pcte_pkg.sv =====
// ----------------------------------------------------------------------------
// pcte_pkg: shared constants, types and character helpers
// ascii codes, field widths and the queue status bundle
// ----------------------------------------------------------------------------
package pcte_pkg;

  localparam int MAX_DIGITS_DEF = 5;
  localparam int COORD_W        = 16;
  localparam int ABGR_W         = 32;
  localparam int RGB_W          = 24;
  localparam int BYTE_W         = 8;
  localparam int BIT_CNT_W      = $clog2(COORD_W + 1);
  localparam int HEX_DIGITS     = 6;
  localparam int HEX_CNT_W      = $clog2(HEX_DIGITS + 1);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [BYTE_W-1:0] CH_P       = 8'h50;
  localparam logic [BYTE_W-1:0] CH_X       = 8'h58;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NL      = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_A_LOWER = 8'h61;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [BYTE_W-1:0] dec_char(input logic [3:0] nib);
    return CH_ZERO + {4'h0, nib};
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [3:0] low;
    low = nib - 4'd10;
    if (nib < 4'd10) begin
      return CH_ZERO + {4'h0, nib};
    end else begin
      return CH_A_LOWER + {4'h0, low};
    end
  endfunction

endpackage

// ===== rtl/pcte_front.sv =====
// ----------------------------------------------------------------------------
// pcte_front: request intake and decimal conversion
// binary to bcd by shift-and-add-3, then leading zero trim, then queue push
// ----------------------------------------------------------------------------
module pcte_front #(
  parameter int MAX_DIGITS = pcte_pkg::MAX_DIGITS_DEF,
  localparam int BCD_W  = 4 * MAX_DIGITS,
  localparam int LEN_W  = $clog2(MAX_DIGITS + 1),
  localparam int DESC_W = 2 * (BCD_W + LEN_W) + pcte_pkg::RGB_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pcte_pkg::COORD_W-1:0] in_x_coord,
  input  logic [pcte_pkg::COORD_W-1:0] in_y_coord,
  input  logic [pcte_pkg::ABGR_W-1:0]  in_pixel_abgr,
  input  pcte_pkg::q_stat_t            q_stat,
  output logic                         q_push,
  output logic [DESC_W-1:0]            q_wdata
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_TRIM} fstate_t;

  fstate_t                          state_r;
  logic [pcte_pkg::COORD_W-1:0]     x_sh_r, y_sh_r;
  logic [BCD_W-1:0]                 x_bcd_r, y_bcd_r;
  logic [LEN_W-1:0]                 x_len_r, y_len_r;
  logic [pcte_pkg::BIT_CNT_W-1:0]   bit_cnt_r;
  logic [pcte_pkg::RGB_W-1:0]       rgb_r;
  logic [BCD_W-1:0]                 x_adj, y_adj;
  logic                             x_can, y_can;

  function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign x_adj = add3(x_bcd_r);
  assign y_adj = add3(y_bcd_r);

  // a leading zero digit can go while more than one digit is left
  assign x_can = (x_bcd_r[BCD_W-1 -: 4] == 4'h0) && (x_len_r != LEN_W'(1));
  assign y_can = (y_bcd_r[BCD_W-1 -: 4] == 4'h0) && (y_len_r != LEN_W'(1));

  assign in_stall = (state_r != F_IDLE);
  assign q_push   = (state_r == F_TRIM) && !x_can && !y_can && !q_stat.full;
  assign q_wdata  = {x_bcd_r, x_len_r, y_bcd_r, y_len_r, rgb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            x_sh_r    <= in_x_coord;
            y_sh_r    <= in_y_coord;
            x_bcd_r   <= '0;
            y_bcd_r   <= '0;
            bit_cnt_r <= pcte_pkg::BIT_CNT_W'(pcte_pkg::COORD_W);
            // red, green, blue in emission order; alpha dropped
            rgb_r     <= {in_pixel_abgr[7:0], in_pixel_abgr[15:8], in_pixel_abgr[23:16]};
            state_r   <= F_CONV;
          end
        end
        F_CONV: begin
          // carry out of the top digit is dropped: value modulo 10^digits
          x_bcd_r   <= {x_adj[BCD_W-2:0], x_sh_r[pcte_pkg::COORD_W-1]};
          y_bcd_r   <= {y_adj[BCD_W-2:0], y_sh_r[pcte_pkg::COORD_W-1]};
          x_sh_r    <= x_sh_r << 1;
          y_sh_r    <= y_sh_r << 1;
          bit_cnt_r <= bit_cnt_r - pcte_pkg::BIT_CNT_W'(1);
          if (bit_cnt_r == pcte_pkg::BIT_CNT_W'(1)) begin
            x_len_r <= LEN_W'(MAX_DIGITS);
            y_len_r <= LEN_W'(MAX_DIGITS);
            state_r <= F_TRIM;
          end
        end
        F_TRIM: begin
          if (x_can) begin
            x_bcd_r <= x_bcd_r << 4;
            x_len_r <= x_len_r - LEN_W'(1);
          end
          if (y_can) begin
            y_bcd_r <= y_bcd_r << 4;
            y_len_r <= y_len_r - LEN_W'(1);
          end
          if (q_push) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pcte_fifo.sv =====
// ----------------------------------------------------------------------------
// pcte_fifo: short descriptor queue
// first-word fall-through register queue between intake and emitter
// ----------------------------------------------------------------------------
module pcte_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcte_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              pop,
  output logic [WIDTH-1:0]  rdata,
  output pcte_pkg::q_stat_t stat
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/pcte_back.sv =====
// ----------------------------------------------------------------------------
// pcte_back: command text emitter
// walks one descriptor through the text fields; while not stalled, one byte per cycle
// ----------------------------------------------------------------------------
module pcte_back #(
  parameter int MAX_DIGITS = pcte_pkg::MAX_DIGITS_DEF,
  localparam int BCD_W  = 4 * MAX_DIGITS,
  localparam int LEN_W  = $clog2(MAX_DIGITS + 1),
  localparam int DESC_W = 2 * (BCD_W + LEN_W) + pcte_pkg::RGB_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcte_pkg::q_stat_t           q_stat,
  input  logic [DESC_W-1:0]           q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pcte_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last_byte
);

  localparam int RGB_W = pcte_pkg::RGB_W;

  typedef enum logic [3:0] {
    B_IDLE, B_P, B_X, B_SP1, B_XD, B_SP2, B_YD, B_SP3, B_HEX, B_NL
  } bstate_t;

  bstate_t                        state_r;
  logic                           out_valid_r;
  logic [pcte_pkg::BYTE_W-1:0]    out_byte_r;
  logic                           out_last_r;
  logic [BCD_W-1:0]               x_dig_r, y_dig_r;
  logic [LEN_W-1:0]               x_cnt_r, y_cnt_r;
  logic [RGB_W-1:0]               rgb_r;
  logic [pcte_pkg::HEX_CNT_W-1:0] hex_cnt_r;
  logic                           advance;
  logic                           emit;

  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && !q_stat.empty && (state_r == B_IDLE || state_r == B_NL);
  // a byte is produced in every active state, and from idle only on a pop
  assign emit    = q_pop ||
                   (state_r inside {B_P, B_X, B_SP1, B_XD, B_SP2, B_YD, B_SP3, B_HEX, B_NL});

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
      out_last_r  <= (state_r == B_NL);
      if (q_pop) begin
        x_dig_r <= q_rdata[DESC_W-1 -: BCD_W];
        x_cnt_r <= q_rdata[DESC_W-BCD_W-1 -: LEN_W];
        y_dig_r <= q_rdata[RGB_W+LEN_W+BCD_W-1 -: BCD_W];
        y_cnt_r <= q_rdata[RGB_W+LEN_W-1 -: LEN_W];
        rgb_r   <= q_rdata[RGB_W-1:0];
      end
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            out_byte_r <= pcte_pkg::CH_P;
            state_r    <= B_X;
          end
        end
        B_P: begin
          out_byte_r <= pcte_pkg::CH_P;
          state_r    <= B_X;
        end
        B_X: begin
          out_byte_r <= pcte_pkg::CH_X;
          state_r    <= B_SP1;
        end
        B_SP1: begin
          out_byte_r <= pcte_pkg::CH_SPACE;
          state_r    <= B_XD;
        end
        B_XD: begin
          out_byte_r <= pcte_pkg::dec_char(x_dig_r[BCD_W-1 -: 4]);
          x_dig_r    <= x_dig_r << 4;
          x_cnt_r    <= x_cnt_r - LEN_W'(1);
          if (x_cnt_r == LEN_W'(1)) begin
            state_r <= B_SP2;
          end
        end
        B_SP2: begin
          out_byte_r <= pcte_pkg::CH_SPACE;
          state_r    <= B_YD;
        end
        B_YD: begin
          out_byte_r <= pcte_pkg::dec_char(y_dig_r[BCD_W-1 -: 4]);
          y_dig_r    <= y_dig_r << 4;
          y_cnt_r    <= y_cnt_r - LEN_W'(1);
          if (y_cnt_r == LEN_W'(1)) begin
            state_r <= B_SP3;
          end
        end
        B_SP3: begin
          out_byte_r <= pcte_pkg::CH_SPACE;
          hex_cnt_r  <= pcte_pkg::HEX_CNT_W'(pcte_pkg::HEX_DIGITS);
          state_r    <= B_HEX;
        end
        B_HEX: begin
          out_byte_r <= pcte_pkg::hex_char(rgb_r[RGB_W-1 -: 4]);
          rgb_r      <= rgb_r << 4;
          hex_cnt_r  <= hex_cnt_r - pcte_pkg::HEX_CNT_W'(1);
          if (hex_cnt_r == pcte_pkg::HEX_CNT_W'(1)) begin
            state_r <= B_NL;
          end
        end
        B_NL: begin
          out_byte_r <= pcte_pkg::CH_NL;
          state_r    <= q_pop ? B_P : B_IDLE;
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pixel_command_text_encoder_core.sv =====
// ----------------------------------------------------------------------------
// pixel_command_text_encoder_core: pixel to "PX x y rrggbb\n" text encoder
// request path: bcd conversion and leading zero trim in the front, then queue and emitter
// throughput: one byte per cycle while out_stall is low; the front takes a new
//   request once it has pushed the previous descriptor, while the emitter streams
// reset: synchronous active-low rst_n clears front, queue and emitter control
// ----------------------------------------------------------------------------
module pixel_command_text_encoder_core #(
  parameter int MAX_DIGITS = pcte_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pcte_pkg::COORD_W-1:0] in_x_coord,
  input  logic [pcte_pkg::COORD_W-1:0] in_y_coord,
  input  logic [pcte_pkg::ABGR_W-1:0]  in_pixel_abgr,
  // text byte channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pcte_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last_byte
);

  // descriptor layout: x digits, x length, y digits, y length, rgb nibbles
  localparam int BCD_W  = 4 * MAX_DIGITS;
  localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
  localparam int DESC_W = 2 * (BCD_W + LEN_W) + pcte_pkg::RGB_W;

  logic              q_push, q_pop;
  logic [DESC_W-1:0] q_wdata, q_rdata;
  pcte_pkg::q_stat_t q_stat;

  // front: takes a request, runs 16 shift-and-add-3 steps for both
  // coordinates side by side, strips leading zeros one digit a cycle,
  // then pushes a descriptor; stalls the input while busy
  pcte_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_pixel_abgr (in_pixel_abgr),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // two-entry queue lets the front convert the next pixel while the
  // emitter is still streaming the current command
  pcte_fifo #(
    .WIDTH (DESC_W),
    .DEPTH (pcte_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: registered byte output, one byte per cycle while not stalled,
  // the next descriptor is loaded on the newline so commands run seamless
  pcte_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

`ifndef SYNTHESIS
  // the flagged byte is always the newline
  a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_byte == pcte_pkg::CH_NL)
    else $error("last byte is not a newline");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("descriptor queue overflow");

  // within a command the bytes follow without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_byte |=> out_valid)
    else $error("gap inside a command");

  // nothing is popped from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("descriptor queue underflow");
`endif

endmodule

// ===== tb/pixel_command_text_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// pixel_command_text_encoder_core_tb: self-checking bench for the px encoder
// drives pixel requests, predicts the "PX x y rrggbb\n" text of each one and
// compares every emitted byte and its last flag against the predicted stream
// ----------------------------------------------------------------------------
module pixel_command_text_encoder_core_tb;

  localparam int BYTE_W       = pcte_pkg::BYTE_W;
  localparam int COORD_W      = pcte_pkg::COORD_W;
  localparam int ABGR_W       = pcte_pkg::ABGR_W;
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_WAIT     = 16;
  localparam int DRAIN_CYCLES = 48;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int REPORT_MAX   = 10;
  localparam int RAND_ITEMS   = 410;
  localparam int CHUNK_ITEMS  = 40;

  // one predicted character of a command
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } text_byte_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [COORD_W-1:0]  in_x_coord;
  logic [COORD_W-1:0]  in_y_coord;
  logic [ABGR_W-1:0]   in_pixel_abgr;
  logic                out_valid;
  logic                out_stall;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last_byte;

  // text still owed by the block, oldest first
  text_byte_t  expected_text[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  // per-side idling switches, set anew between stretches of requests
  bit          tx_idle;
  bit          rx_idle;
  int unsigned rx_hold;

  pixel_command_text_encoder_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_pixel_abgr (in_pixel_abgr),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run guard: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // text predictor
  // ---------------------------------------------------------------------------

  function automatic void push_text(input logic [BYTE_W-1:0] ch, input logic last);
    text_byte_t tb;
    tb.ch   = ch;
    tb.last = last;
    expected_text.push_back(tb);
  endfunction

  // lowercase hex ascii for one nibble
  function automatic logic [BYTE_W-1:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return pcte_pkg::CH_ZERO + BYTE_W'(nib);
    end else begin
      return pcte_pkg::CH_A_LOWER + BYTE_W'(nib - 4'd10);
    end
  endfunction

  // decimal without leading zeros, only the low MAX_DIGITS digits survive
  function automatic void push_decimal(input logic [COORD_W-1:0] coord);
    int unsigned digits[$];
    int unsigned v;
    v = int'(coord) % (10 ** pcte_pkg::MAX_DIGITS_DEF);
    if (v == 0) begin
      push_text(pcte_pkg::CH_ZERO, 1'b0);
    end else begin
      while (v != 0) begin
        digits.push_front(v % 10);
        v = v / 10;
      end
      foreach (digits[i]) push_text(pcte_pkg::CH_ZERO + BYTE_W'(digits[i]), 1'b0);
    end
  endfunction

  function automatic void push_hex_byte(input logic [7:0] b);
    push_text(nibble_ascii(b[7:4]), 1'b0);
    push_text(nibble_ascii(b[3:0]), 1'b0);
  endfunction

  // whole command for one pixel; alpha in bits 31:24 never enters the text
  function automatic void predict_px_command(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y,
                                             input logic [ABGR_W-1:0]  abgr);
    push_text(pcte_pkg::CH_P, 1'b0);
    push_text(pcte_pkg::CH_X, 1'b0);
    push_text(pcte_pkg::CH_SPACE, 1'b0);
    push_decimal(x);
    push_text(pcte_pkg::CH_SPACE, 1'b0);
    push_decimal(y);
    push_text(pcte_pkg::CH_SPACE, 1'b0);
    push_hex_byte(abgr[7:0]);
    push_hex_byte(abgr[15:8]);
    push_hex_byte(abgr[23:16]);
    push_text(pcte_pkg::CH_NL, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // one pixel request; valid stays high between back-to-back requests
  task automatic send_pixel(input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y,
                            input logic [ABGR_W-1:0]  abgr);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    // idle cycles carry junk payload so only valid qualifies the fields
    repeat (gap) begin
      in_valid      <= 1'b0;
      in_x_coord    <= COORD_W'($urandom);
      in_y_coord    <= COORD_W'($urandom);
      in_pixel_abgr <= $urandom;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_x_coord    <= x;
    in_y_coord    <= y;
    in_pixel_abgr <= abgr;
    // hold the request until it is taken at a rising edge
    do @(posedge clk); while (in_stall);
    predict_px_command(x, y, abgr);
  endtask

  // coordinates spread over every decimal width, zero included
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return COORD_W'($urandom_range(1, 9));
      2:       return COORD_W'($urandom_range(10, 99));
      3:       return COORD_W'($urandom_range(100, 999));
      4:       return COORD_W'($urandom_range(1000, 9999));
      5:       return COORD_W'($urandom_range(10000, 65535));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // byte receiver and checker
  // ---------------------------------------------------------------------------

  // stall for a drawn number of cycles after each taken byte
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold   <= rx_hold - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    text_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      rx_hold <= rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (expected_text.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected byte %h last %b with nothing pending",
                   out_byte, out_last_byte);
      end else begin
        want = expected_text.pop_front();
        if (out_byte !== want.ch || out_last_byte !== want.last) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= REPORT_MAX)
            $display("byte mismatch: expected %h last %b, got %h last %b",
                     want.ch, want.last, out_byte, out_last_byte);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // decimal widths at their boundaries, zero coordinates and full range
  task automatic test_coord_extremes();
    send_pixel(16'd0,     16'd0,     32'h0000_0000);
    send_pixel(16'd65535, 16'd65535, 32'hffff_ffff);
    send_pixel(16'd0,     16'd65535, 32'h0012_3456);
    send_pixel(16'd65535, 16'd0,     32'h00ab_cdef);
    send_pixel(16'd9,     16'd10,    32'h0101_0101);
    send_pixel(16'd99,    16'd100,   32'h8080_8080);
    send_pixel(16'd999,   16'd1000,  32'h7f7f_7f7f);
    send_pixel(16'd9999,  16'd10000, 32'h0908_0706);
    send_pixel(16'd1,     16'd1,     32'h00ff_00ff);
    send_pixel(16'd10000, 16'd9999,  32'h0000_ff00);
    send_pixel(16'h5555,  16'haaaa,  32'h5555_5555);
    send_pixel(16'haaaa,  16'h5555,  32'haaaa_aaaa);
  endtask

  // every hex digit in the colour field, alpha must not leak
  task automatic test_colour_digits();
    send_pixel(16'd12, 16'd34, 32'h0f0f_0f0f);
    send_pixel(16'd12, 16'd34, 32'hf0f0_f0f0);
    send_pixel(16'd12, 16'd34, 32'h0089_abcd);
    send_pixel(16'd12, 16'd34, 32'h00ef_0123);
    send_pixel(16'd12, 16'd34, 32'h0045_6789);
    // same color under different alpha gives the same text, then full alpha over black
    send_pixel(16'd7, 16'd8, 32'h00c0_ffee);
    send_pixel(16'd7, 16'd8, 32'hffc0_ffee);
    send_pixel(16'd7, 16'd8, 32'h5ac0_ffee);
    send_pixel(16'd7, 16'd8, 32'hff00_0000);
  endtask

  // random pixels in stretches, each stretch with its own idling mix
  task automatic test_random_pixels();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      send_pixel(rand_coord(), rand_coord(), $urandom);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_x_coord    = '0;
    in_y_coord    = '0;
    in_pixel_abgr = '0;
    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    rx_hold       = 0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // coordinate extremes run first without any idling, colour digits with both sides idling
    test_coord_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_colour_digits();
    test_random_pixels();

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then leave room for any stray trailing byte
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
